// ===== hw/rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

   localparam int FUNC_BITS = 4;
   localparam int EXP_BITS  = 6;

   typedef enum logic [3:0] {
      FN_NORM  = 4'd0,
      FN_ADD   = 4'd1,
      FN_SUB   = 4'd2,
      FN_MUL   = 4'd3,
      FN_DIV   = 4'd4,
      FN_POW   = 4'd5,
      FN_SCALE = 4'd6,
      FN_DIVI  = 4'd7,
      FN_EQ    = 4'd8
   } func_type;

   // back end states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_POW,
      ST_GCD,
      ST_DIVSTEP,
      ST_LCM_MUL,
      ST_ADD_MUL,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/rau_front.sv =====
`timescale 1ns / 1ps
// Accepts request words, decodes opcode, holds a two-entry queue to the back end.
module rau_front
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_BITS-1:0]  req_func,
   input  logic [WORD_BITS-1:0]  req_a_num,
   input  logic [WORD_BITS-1:0]  req_a_den,
   input  logic [WORD_BITS-1:0]  req_b_num,
   input  logic [WORD_BITS-1:0]  req_b_den,
   input  logic [EXP_BITS-1:0]   req_exponent,
   input  logic [WORD_BITS-1:0]  req_factor,
   output logic                  q_valid,
   input  logic                  q_pop,
   output logic                  q_known,
   output logic [FUNC_BITS-1:0]  q_func,
   output logic [WORD_BITS-1:0]  q_a_num,
   output logic [WORD_BITS-1:0]  q_a_den,
   output logic [WORD_BITS-1:0]  q_b_num,
   output logic [WORD_BITS-1:0]  q_b_den,
   output logic [EXP_BITS-1:0]   q_exponent,
   output logic [WORD_BITS-1:0]  q_factor
);

   localparam int EW = FUNC_BITS + 1 + EXP_BITS + 5 * WORD_BITS;

   logic [EW-1:0] mem_ff [2];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, known;
   logic [EW-1:0] entry;

   assign known = (req_func <= FN_EQ);
   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign entry = {known, req_func, req_exponent, req_a_num, req_a_den,
                   req_b_num, req_b_den, req_factor};
   assign q_valid = (cnt_ff != 2'd0);
   assign {q_known, q_func, q_exponent, q_a_num, q_a_den, q_b_num, q_b_den,
           q_factor} = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= entry;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_under: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != 2'd0) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad queue count");

endmodule

// ===== hw/rtl/rau_divider.sv =====
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, truncating.
module rau_divider
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] quot,
   output logic [WORD_BITS-1:0] rem
);

   localparam int CW = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] q_ff, q_in, d_ff, d_in;
   logic [WORD_BITS:0]   r_ff, r_in, trial;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS-1:0] ma, mb;

   assign ma = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
   assign mb = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
   assign trial = {r_ff[WORD_BITS-1:0], q_ff[WORD_BITS-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff; done_in = 1'b0;
      if (start) begin
         q_in = ma; d_in = mb; r_in = '0;
         cnt_in = CW'(WORD_BITS); busy_in = 1'b1;
         qneg_in = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
         rneg_in = dividend[WORD_BITS-1];
      end else if (busy_ff) begin
         if (!trial[WORD_BITS]) begin
            r_in = trial;
            q_in = {q_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            r_in = {r_ff[WORD_BITS-1:0], q_ff[WORD_BITS-1]};
            q_in = {q_ff[WORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign done = done_ff;
   assign quot = qneg_ff ? (~q_ff + 1'b1) : q_ff;
   assign rem  = rneg_ff ? (~r_ff[WORD_BITS-1:0] + 1'b1) : r_ff[WORD_BITS-1:0];

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("bad divide count");

endmodule

// ===== hw/rtl/rau_back.sv =====
`timescale 1ns / 1ps
// Sequencer: gcd loop, lcm, quotients and powers on one multiplier and one divider.
module rau_back
   import rau_pkg::*;
#(
   parameter int WORD_BITS    = 32,
   parameter int MAX_EXPONENT = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic                  q_known,
   input  logic [FUNC_BITS-1:0]  q_func,
   input  logic [WORD_BITS-1:0]  q_a_num,
   input  logic [WORD_BITS-1:0]  q_a_den,
   input  logic [WORD_BITS-1:0]  q_b_num,
   input  logic [WORD_BITS-1:0]  q_b_den,
   input  logic [EXP_BITS-1:0]   q_exponent,
   input  logic [WORD_BITS-1:0]  q_factor,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_BITS-1:0]  rsp_res_num,
   output logic [WORD_BITS-1:0]  rsp_res_den,
   output logic                  rsp_is_equal,
   output logic                  rsp_div_error
);

   localparam int XB = (MAX_EXPONENT > 31) ? $clog2(MAX_EXPONENT + 1) : EXP_BITS;

   // divide purposes
   typedef enum logic [2:0] {
      DV_GCD, DV_NORM_N, DV_NORM_D, DV_LCM, DV_ADD_A, DV_ADD_B
   } dv_type;

   state_type            st_ff, st_in;
   dv_type               dv_ff, dv_in;
   func_type             fn_ff, fn_in;
   logic [WORD_BITS-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [WORD_BITS-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in, l_ff, l_in;
   logic [WORD_BITS-1:0] rn_ff, rn_in, rd_ff, rd_in, t_ff, t_in;
   logic [XB-1:0]        m_ff, m_in;
   logic                 err_ff, err_in, eq_ff, eq_in, half_ff, half_in;
   logic                 ov_ff, ov_in;
   logic [WORD_BITS-1:0] on_ff, on_in, od_ff, od_in;
   logic                 oeq_ff, oeq_in, oerr_ff, oerr_in;
   logic                 dv_start;
   logic [WORD_BITS-1:0] dv_x, dv_y, dv_q, dv_r;
   logic                 dv_done;
   logic [WORD_BITS-1:0] mul_a, mul_b, prod;
   logic [EXP_BITS-1:0]  emag;

   rau_divider #(.WORD_BITS(WORD_BITS)) u_div (
      .clock, .reset, .start(dv_start), .dividend(dv_x), .divisor(dv_y),
      .done(dv_done), .quot(dv_q), .rem(dv_r)
   );

   assign prod = mul_a * mul_b;
   assign emag = q_exponent[EXP_BITS-1] ? (~q_exponent + 1'b1) : q_exponent;

   always_comb begin
      st_in = st_ff; dv_in = dv_ff; fn_in = fn_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; g_in = g_ff; l_in = l_ff;
      rn_in = rn_ff; rd_in = rd_ff; t_in = t_ff; m_in = m_ff;
      err_in = err_ff; eq_in = eq_ff; half_in = half_ff;
      ov_in = ov_ff; on_in = on_ff; od_in = od_ff; oeq_in = oeq_ff; oerr_in = oerr_ff;
      q_pop = 1'b0; dv_start = 1'b0; dv_x = x_ff; dv_y = y_ff;
      mul_a = rn_ff; mul_b = an_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               fn_in = func_type'(q_func);
               an_in = q_a_num; ad_in = q_a_den;
               bn_in = (func_type'(q_func) == FN_SUB) ? (~q_b_num + 1'b1) : q_b_num;
               bd_in = q_b_den;
               rn_in = '0; rd_in = '0; err_in = 1'b0; eq_in = 1'b0; half_in = 1'b0;
               st_in = ST_DONE;
               if (q_known) begin
                  unique case (func_type'(q_func))
                     FN_NORM: begin
                        x_in = q_a_num; y_in = q_a_den; dv_in = DV_GCD; st_in = ST_GCD;
                     end
                     FN_ADD, FN_SUB: begin
                        x_in = q_a_den; y_in = q_b_den; dv_in = DV_GCD; st_in = ST_GCD;
                     end
                     FN_MUL, FN_DIV, FN_SCALE, FN_DIVI: st_in = ST_MUL;
                     FN_POW: begin
                        if (q_exponent[EXP_BITS-1]) begin
                           an_in = q_a_den; ad_in = q_a_num;
                        end
                        if (emag == '0) begin
                           rn_in = WORD_BITS'(1); rd_in = WORD_BITS'(1); st_in = ST_DONE;
                        end else begin
                           rn_in = q_exponent[EXP_BITS-1] ? q_a_den : q_a_num;
                           rd_in = q_exponent[EXP_BITS-1] ? q_a_num : q_a_den;
                           m_in = (XB'(emag) > XB'(MAX_EXPONENT)) ? XB'(MAX_EXPONENT)
                                                                   : XB'(emag);
                           st_in = ST_POW;
                        end
                     end
                     FN_EQ: eq_in = (q_a_num == q_b_num) && (q_a_den == q_b_den);
                     default: st_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_MUL: begin
            // two products, numerator then denominator; t_ff holds the saved factor
            unique case (fn_ff)
               FN_MUL: begin
                  mul_a = half_ff ? ad_ff : an_ff; mul_b = half_ff ? bd_ff : bn_ff;
               end
               FN_DIV: begin
                  mul_a = half_ff ? ad_ff : an_ff; mul_b = half_ff ? bn_ff : bd_ff;
               end
               FN_SCALE: begin
                  mul_a = half_ff ? ad_ff : an_ff; mul_b = half_ff ? WORD_BITS'(1) : t_ff;
               end
               default: begin
                  mul_a = half_ff ? ad_ff : an_ff; mul_b = half_ff ? t_ff : WORD_BITS'(1);
               end
            endcase
            if (!half_ff) begin
               rn_in = prod; half_in = 1'b1;
            end else begin
               rd_in = prod; st_in = ST_DONE;
            end
         end
         ST_POW: begin
            if (m_ff == XB'(1)) st_in = ST_DONE;
            else begin
               if (!half_ff) begin
                  mul_a = rn_ff; mul_b = an_ff; rn_in = prod; half_in = 1'b1;
               end else begin
                  mul_a = rd_ff; mul_b = ad_ff; rd_in = prod; half_in = 1'b0;
                  m_in = m_ff - 1'b1;
               end
            end
         end
         ST_GCD: begin
            if (y_ff == '0) begin
               g_in = x_ff;
               if (x_ff == '0) begin
                  err_in = 1'b1; st_in = ST_DONE;
               end else if (fn_ff == FN_NORM) begin
                  dv_x = an_ff; dv_y = x_ff; dv_start = 1'b1; dv_in = DV_NORM_N;
                  st_in = ST_DIVSTEP;
               end else begin
                  st_in = ST_LCM_MUL;
               end
            end else begin
               dv_start = 1'b1; st_in = ST_DIVSTEP; dv_in = DV_GCD;
            end
         end
         ST_LCM_MUL: begin
            mul_a = ad_ff; mul_b = bd_ff;
            dv_x = prod; dv_y = g_ff; dv_start = 1'b1; dv_in = DV_LCM;
            st_in = ST_DIVSTEP;
         end
         ST_DIVSTEP: begin
            if (dv_done) begin
               unique case (dv_ff)
                  DV_GCD: begin
                     x_in = y_ff; y_in = dv_r; st_in = ST_GCD;
                  end
                  DV_NORM_N: begin
                     rn_in = dv_q; dv_x = ad_ff; dv_y = g_ff; dv_start = 1'b1;
                     dv_in = DV_NORM_D;
                  end
                  DV_NORM_D: begin
                     rd_in = dv_q; st_in = ST_DONE;
                  end
                  DV_LCM: begin
                     l_in = dv_q; rd_in = dv_q;
                     if (ad_ff == '0 || bd_ff == '0) begin
                        err_in = 1'b1; st_in = ST_DONE;
                     end else begin
                        dv_x = dv_q; dv_y = ad_ff; dv_start = 1'b1; dv_in = DV_ADD_A;
                     end
                  end
                  DV_ADD_A: begin
                     t_in = dv_q; dv_x = l_ff; dv_y = bd_ff; dv_start = 1'b1;
                     dv_in = DV_ADD_B;
                  end
                  default: begin
                     y_in = dv_q; half_in = 1'b0; st_in = ST_ADD_MUL;
                  end
               endcase
            end
         end
         ST_ADD_MUL: begin
            if (!half_ff) begin
               mul_a = an_ff; mul_b = t_ff; rn_in = prod; half_in = 1'b1;
            end else begin
               mul_a = bn_ff; mul_b = y_ff; rn_in = rn_ff + prod; st_in = ST_DONE;
            end
         end
         default: begin
            // ST_DONE: hand to the output register when free
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               on_in = err_ff ? '0 : rn_ff;
               od_in = err_ff ? '0 : rd_ff;
               oeq_in = eq_ff; oerr_in = err_ff;
               half_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
      dv_ff <= dv_in; fn_ff <= fn_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; g_ff <= g_in; l_ff <= l_in;
      rn_ff <= rn_in; rd_ff <= rd_in; m_ff <= m_in;
      t_ff <= (st_ff == ST_IDLE && q_valid) ? q_factor : t_in;
      err_ff <= err_in; eq_ff <= eq_in; half_ff <= half_in;
      on_ff <= on_in; od_ff <= od_in; oeq_ff <= oeq_in; oerr_ff <= oerr_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_res_num   = on_ff;
   assign rsp_res_den   = od_ff;
   assign rsp_is_equal  = oeq_ff;
   assign rsp_div_error = oerr_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      ov_ff && oerr_ff |-> on_ff == '0 && od_ff == '0) else $error("error result not zero");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == ST_IDLE) else $error("pop while busy");
   a_eq_excl: assert property (@(posedge clock) disable iff (reset)
      ov_ff && oeq_ff |-> !oerr_ff) else $error("equal and error both set");

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Mul/div/scale/divide-by-int take two products; equal and unused opcodes go straight
//   to the done state; power takes one product pair per exponent step past the first;
//   normalize/add/sub take one divider pass per gcd step and two or three more passes.
// Throughput: one word at a time in the back end; the front queue holds two.
// The shared divider and the gcd remainder loop set the rate.
// Reset: synchronous, active high; clears queue, sequencer and output valid.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS    = 32,
   parameter int MAX_EXPONENT = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_BITS-1:0]  req_func,
   input  logic [WORD_BITS-1:0]  req_a_num,
   input  logic [WORD_BITS-1:0]  req_a_den,
   input  logic [WORD_BITS-1:0]  req_b_num,
   input  logic [WORD_BITS-1:0]  req_b_den,
   input  logic [EXP_BITS-1:0]   req_exponent,
   input  logic [WORD_BITS-1:0]  req_factor,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_BITS-1:0]  rsp_res_num,
   output logic [WORD_BITS-1:0]  rsp_res_den,
   output logic                  rsp_is_equal,
   output logic                  rsp_div_error
);

   logic                 q_valid, q_pop, q_known;
   logic [FUNC_BITS-1:0] q_func;
   logic [WORD_BITS-1:0] q_a_num, q_a_den, q_b_num, q_b_den, q_factor;
   logic [EXP_BITS-1:0]  q_exponent;

   // front: accept and classify words
   rau_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_a_num, .req_a_den,
      .req_b_num, .req_b_den, .req_exponent, .req_factor,
      .q_valid, .q_pop, .q_known, .q_func, .q_a_num, .q_a_den, .q_b_num,
      .q_b_den, .q_exponent, .q_factor
   );

   // back: execute one word at a time
   rau_back #(.WORD_BITS(WORD_BITS), .MAX_EXPONENT(MAX_EXPONENT)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_known, .q_func, .q_a_num, .q_a_den,
      .q_b_num, .q_b_den, .q_exponent, .q_factor,
      .rsp_valid, .rsp_ready, .rsp_res_num, .rsp_res_den, .rsp_is_equal,
      .rsp_div_error
   );

endmodule
